[hdl/vas_pkg.sv]
package vas_pkg;

  localparam int MaxVoices = 64;
  localparam int DefVoices = 16;

  localparam logic [2:0] MODE_ALLOC  = 3'd0;
  localparam logic [2:0] MODE_PITCH  = 3'd1;
  localparam logic [2:0] MODE_VOLUME = 3'd2;
  localparam logic [2:0] MODE_PAN    = 3'd3;
  localparam logic [2:0] MODE_STOP   = 3'd4;
  localparam logic [2:0] MODE_QUERY  = 3'd5;

  localparam logic [4:0] FL_START = 5'b00001;
  localparam logic [4:0] FL_STOP  = 5'b00010;
  localparam logic [4:0] FL_PITCH = 5'b00100;
  localparam logic [4:0] FL_VOL   = 5'b01000;
  localparam logic [4:0] FL_PAN   = 5'b10000;

  localparam logic [31:0] NO_ID = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    K_ALLOC  = 2'd0,
    K_EDIT   = 2'd1,
    K_QUERY  = 2'd2,
    K_REJECT = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  mode;
    logic [5:0]  voice;
    logic [31:0] ticket;
    logic [31:0] instrument;
    logic [31:0] start_position;
    logic [31:0] wave_length;
    logic [31:0] loop_end;
    logic [7:0]  loop_count;
    logic [15:0] pitch;
    logic [7:0]  volume;
    logic [7:0]  pan;
    logic [7:0]  steal_priority;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

[hdl/vas_front.sv]
module vas_front #(
  parameter int VOICES = vas_pkg::DefVoices
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [2:0]    mode,
  input  logic [5:0]    voice,
  input  logic [31:0]   ticket,
  input  logic [31:0]   instrument,
  input  logic [31:0]   start_position,
  input  logic [31:0]   wave_length,
  input  logic [31:0]   loop_end,
  input  logic [7:0]    loop_count,
  input  logic [15:0]   pitch,
  input  logic [7:0]    volume,
  input  logic [7:0]    pan,
  input  logic [7:0]    steal_priority,
  output logic          push,
  output vas_pkg::cmd_t push_data,
  input  logic          q_full
);
  import vas_pkg::*;

  logic  held;
  cmd_t  cmd;
  kind_t kind;

  always_comb begin
    if (mode == MODE_ALLOC) begin
      kind = K_ALLOC;
    end else if (mode > MODE_QUERY || {1'b0, voice} >= 7'(VOICES)) begin
      kind = K_REJECT;
    end else if (mode == MODE_QUERY) begin
      kind = K_QUERY;
    end else begin
      kind = K_EDIT;
    end
  end

  assign push      = held && !q_full;
  assign in_stall  = held && q_full;
  assign push_data = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      cmd <= '{kind: kind, mode: mode, voice: voice, ticket: ticket,
               instrument: instrument, start_position: start_position,
               wave_length: wave_length, loop_end: loop_end,
               loop_count: loop_count, pitch: pitch, volume: volume, pan: pan,
               steal_priority: steal_priority};
    end
  end

endmodule

[hdl/vas_queue.sv]
module vas_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  vas_pkg::cmd_t    push_data,
  input  logic             pop,
  output vas_pkg::cmd_t    head,
  output vas_pkg::q_stat_t stat
);
  import vas_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head       = slot[rd_ptr];
  assign stat.valid = count != 2'd0;
  assign stat.full  = count == 2'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

[hdl/vas_back.sv]
module vas_back #(
  parameter int VOICES = vas_pkg::DefVoices
) (
  input  logic             clk,
  input  logic             rst,
  input  vas_pkg::cmd_t    head,
  input  vas_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             ok,
  output logic [5:0]       voice_index,
  output logic [31:0]      voice_id,
  output logic             active,
  output logic [31:0]      position,
  output logic [4:0]       pending_flags,
  output logic [6:0]       free_voices
);
  import vas_pkg::*;

  localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [6:0] NV = 7'(VOICES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WAIT = 4'b0010,
    S_SCAN = 4'b0100,
    S_EXEC = 4'b1000
  } state_t;

  state_t state;
  cmd_t   c;

  logic [5:0]     fs_mem  [VOICES];
  logic [31:0]    id_mem  [VOICES];
  logic [31:0]    pos_mem [VOICES];
  logic [111:0]   par_mem [VOICES];
  logic [15:0]    pit_mem [VOICES];
  logic [7:0]     vol_mem [VOICES];
  logic [7:0]     pan_mem [VOICES];
  logic [VOICES-1:0] fs_vld;
  logic [VOICES-1:0] act;
  logic [4:0]     flags [VOICES];

  logic [6:0]     used;
  logic [31:0]    id_ctr;
  logic [VIW-1:0] rd_addr;
  logic [VIW-1:0] rd_tag;
  logic           rd_live;
  logic [31:0]    id_rd;
  logic [31:0]    pos_rd;
  logic [VIW-1:0] fs_rd;
  logic [31:0]    best;
  logic [VIW-1:0] best_idx;

  logic [VIW-1:0] ua;
  logic [VIW-1:0] v;
  logic [VIW-1:0] sel;
  logic           alloc_free;
  logic           alloc_steal;
  logic           match;
  logic [6:0]     used_next;
  logic [31:0]    id_next;

  logic           ok_next;
  logic [5:0]     voice_index_next;
  logic [31:0]    voice_id_next;
  logic           active_next;
  logic [31:0]    position_next;
  logic [4:0]     pending_flags_next;

  assign ua          = used[VIW-1:0];
  assign v           = c.voice[VIW-1:0];
  assign alloc_free  = used < NV;
  assign alloc_steal = !alloc_free && c.steal_priority != 8'd0;
  assign sel         = alloc_free ? fs_rd : best_idx;
  assign match       = act[v] && id_rd == c.ticket;
  assign id_next     = id_ctr + 32'd1;
  assign pop         = state == S_IDLE && q_stat.valid && !out_valid;

  always_comb begin
    used_next = used;
    if (c.kind == K_ALLOC && alloc_free) begin
      used_next = used + 7'd1;
    end else if (c.kind == K_EDIT && match && c.mode == MODE_STOP && used != 7'd0) begin
      used_next = used - 7'd1;
    end
  end

  always_comb begin
    ok_next            = 1'b0;
    voice_index_next   = c.voice;
    voice_id_next      = 32'd0;
    active_next        = act[v];
    position_next      = pos_rd;
    pending_flags_next = flags[v];
    unique case (c.kind)
      K_ALLOC: begin
        if (alloc_free || alloc_steal) begin
          ok_next            = 1'b1;
          voice_index_next   = 6'(sel);
          voice_id_next      = id_next;
          active_next        = 1'b1;
          position_next      = c.start_position;
          pending_flags_next = alloc_steal ? (FL_START | FL_STOP) : FL_START;
        end else begin
          voice_index_next   = 6'd0;
          active_next        = 1'b0;
          position_next      = 32'd0;
          pending_flags_next = 5'd0;
        end
      end
      K_REJECT: begin
        active_next        = 1'b0;
        position_next      = 32'd0;
        pending_flags_next = 5'd0;
      end
      K_QUERY: begin
        ok_next       = 1'b1;
        voice_id_next = id_rd;
      end
      K_EDIT: begin
        if (match) begin
          ok_next = 1'b1;
          unique case (c.mode)
            MODE_PITCH:  pending_flags_next = flags[v] | FL_PITCH;
            MODE_VOLUME: pending_flags_next = flags[v] | FL_VOL;
            MODE_PAN:    pending_flags_next = flags[v] | FL_PAN;
            default: begin
              pending_flags_next = FL_STOP;
              active_next        = 1'b0;
            end
          endcase
        end
      end
      default: ok_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    id_rd  <= id_mem[rd_addr];
    pos_rd <= pos_mem[rd_addr];
    fs_rd  <= fs_vld[ua] ? fs_mem[ua][VIW-1:0] : ua;
    rd_tag <= rd_addr;
    if (state == S_EXEC) begin
      if (c.kind == K_ALLOC && (alloc_free || alloc_steal)) begin
        id_mem[sel]  <= id_next;
        pos_mem[sel] <= c.start_position;
        par_mem[sel] <= {c.instrument, c.wave_length, c.loop_end, c.loop_count,
                         c.steal_priority};
        pit_mem[sel] <= c.pitch;
        vol_mem[sel] <= c.volume;
        pan_mem[sel] <= c.pan;
      end else if (c.kind == K_EDIT && match) begin
        if (c.mode == MODE_PITCH) begin
          pit_mem[v] <= c.pitch;
        end
        if (c.mode == MODE_VOLUME) begin
          vol_mem[v] <= c.volume;
        end
        if (c.mode == MODE_PAN) begin
          pan_mem[v] <= c.pan;
        end
        if (c.mode == MODE_STOP && used != 7'd0) begin
          fs_mem[used_next[VIW-1:0]] <= c.voice;
        end
      end
    end
    if (pop) begin
      c <= head;
    end
    if (state == S_EXEC) begin
      ok            <= ok_next;
      voice_index   <= voice_index_next;
      voice_id      <= voice_id_next;
      active        <= active_next;
      position      <= position_next;
      pending_flags <= pending_flags_next;
      free_voices   <= NV - used_next;
    end
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      used      <= 7'd0;
      id_ctr    <= 32'd0;
      fs_vld    <= '0;
      act       <= '0;
      rd_addr   <= '0;
      rd_live   <= 1'b0;
      best      <= NO_ID;
      best_idx  <= '0;
      for (int i = 0; i < VOICES; i++) begin
        flags[i] <= 5'd0;
      end
    end else begin
      rd_live <= state == S_SCAN;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            best     <= NO_ID;
            best_idx <= '0;
            if (head.kind == K_ALLOC && !alloc_free && head.steal_priority != 8'd0) begin
              rd_addr <= '0;
              state   <= S_SCAN;
            end else begin
              rd_addr <= head.voice[VIW-1:0];
              state   <= S_WAIT;
            end
          end
        end
        S_WAIT: state <= S_EXEC;
        S_SCAN: begin
          if (rd_addr != VIW'(VOICES - 1)) begin
            rd_addr <= rd_addr + VIW'(1);
          end
          if (rd_live && act[rd_tag] && id_rd < best) begin
            best     <= id_rd;
            best_idx <= rd_tag;
          end
          if (rd_live && rd_tag == VIW'(VOICES - 1)) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
          used      <= used_next;
          if (c.kind == K_ALLOC && (alloc_free || alloc_steal)) begin
            id_ctr     <= id_next;
            act[sel]   <= 1'b1;
            flags[sel] <= alloc_steal ? (FL_START | FL_STOP) : FL_START;
          end else if (c.kind == K_EDIT && match) begin
            unique case (c.mode)
              MODE_PITCH:  flags[v] <= flags[v] | FL_PITCH;
              MODE_VOLUME: flags[v] <= flags[v] | FL_VOL;
              MODE_PAN:    flags[v] <= flags[v] | FL_PAN;
              default: begin
                flags[v] <= FL_STOP;
                act[v]   <= 1'b0;
                if (used != 7'd0) begin
                  fs_vld[used_next[VIW-1:0]] <= 1'b1;
                end
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/voice_allocator_with_steal.sv]
// Voice pool manager: allocate (free-stack pop, or steal of the active voice with the
// smallest id when full and stealing is allowed), pitch/volume/pan update and stop by
// ticket, and query. One result per command. A command passes through the back end as
// queue pop, memory read, execute and result register, and an allocate that steals
// first runs an id scan that reads one voice a cycle from the id memory.
// The front register and a two-entry queue accept further commands meanwhile.
module voice_allocator_with_steal #(
  parameter int VOICES = vas_pkg::DefVoices
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [5:0]  voice,
  input  logic [31:0] ticket,
  input  logic [31:0] instrument,
  input  logic [31:0] start_position,
  input  logic [31:0] wave_length,
  input  logic [31:0] loop_end,
  input  logic [7:0]  loop_count,
  input  logic [15:0] pitch,
  input  logic [7:0]  volume,
  input  logic [7:0]  pan,
  input  logic [7:0]  steal_priority,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [5:0]  voice_index,
  output logic [31:0] voice_id,
  output logic        active,
  output logic [31:0] position,
  output logic [4:0]  pending_flags,
  output logic [6:0]  free_voices
);
  import vas_pkg::*;

  logic    push;
  logic    pop;
  cmd_t    push_data;
  cmd_t    head;
  q_stat_t q_stat;

  vas_front #(.VOICES(VOICES)) u_front (
    .clk, .rst, .in_valid, .in_stall, .mode, .voice, .ticket, .instrument,
    .start_position, .wave_length, .loop_end, .loop_count, .pitch, .volume,
    .pan, .steal_priority, .push, .push_data, .q_full(q_stat.full)
  );

  vas_queue u_queue (
    .clk, .rst, .push, .push_data, .pop, .head, .stat(q_stat)
  );

  vas_back #(.VOICES(VOICES)) u_back (
    .clk, .rst, .head, .q_stat, .pop, .out_valid, .out_stall, .ok, .voice_index,
    .voice_id, .active, .position, .pending_flags, .free_voices
  );

  a_free_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> free_voices <= 7'(VOICES))
    else $error("free count above pool size");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push |=> q_stat.valid)
    else $error("queued command lost");

  a_fail_no_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> voice_id == 32'd0)
    else $error("failed command reports an id");

  a_pop_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_stat.valid && !out_valid)
    else $error("pop without room for result");

endmodule

[bench/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import vas_pkg::*;

  localparam int NVOICES = DefVoices;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic        ok;
    logic [5:0]  voice_index;
    logic [31:0] voice_id;
    logic        active;
    logic [31:0] position;
    logic [4:0]  pending_flags;
    logic [6:0]  free_voices;
  } voice_report_t;

  class pool_scoreboard;
    logic [5:0]  free_stack[64];
    int unsigned used_count;
    logic [31:0] id_counter;
    logic        active_mark[64];
    logic [31:0] voice_ids[64];
    logic [4:0]  flag_bits[64];
    logic [31:0] positions[64];
    voice_report_t expected_reports[$];
    int errors;

    function new();
      for (int i = 0; i < 64; i++) begin
        free_stack[i] = i[5:0];
        active_mark[i] = 1'b0;
        voice_ids[i] = '0;
        flag_bits[i] = '0;
        positions[i] = '0;
      end
      used_count = 0;
      id_counter = '0;
      errors = 0;
    endfunction

    function voice_report_t report(logic ok, logic [5:0] idx, logic [31:0] id, bit show);
      voice_report_t r;
      r.ok = ok;
      r.voice_index = idx;
      r.voice_id = id;
      r.active = show ? active_mark[idx] : 1'b0;
      r.position = show ? positions[idx] : '0;
      r.pending_flags = show ? flag_bits[idx] : '0;
      r.free_voices = 7'(NVOICES - used_count);
      return r;
    endfunction

    function void note_command(cmd_t c);
      logic [5:0] sel;
      logic [31:0] best;
      bit stolen;
      sel = '0;
      stolen = 0;
      if (c.mode == MODE_ALLOC) begin
        if (used_count < NVOICES) begin
          sel = free_stack[used_count];
          used_count++;
        end else if (c.steal_priority != 0) begin
          best = NO_ID;
          for (int i = 0; i < NVOICES; i++)
            if (active_mark[i] && voice_ids[i] < best) begin
              best = voice_ids[i];
              sel = i[5:0];
            end
          stolen = 1;
        end else begin
          expected_reports.push_back(report(1'b0, '0, '0, 0));
          return;
        end
        id_counter++;
        positions[sel] = c.start_position;
        flag_bits[sel] = stolen ? (FL_START | FL_STOP) : FL_START;
        active_mark[sel] = 1'b1;
        voice_ids[sel] = id_counter;
        expected_reports.push_back(report(1'b1, sel, id_counter, 1));
        return;
      end
      if (c.mode > MODE_QUERY || c.voice >= NVOICES) begin
        expected_reports.push_back(report(1'b0, c.voice, '0, 0));
        return;
      end
      if (c.mode == MODE_QUERY) begin
        expected_reports.push_back(report(1'b1, c.voice, voice_ids[c.voice], 1));
        return;
      end
      if (!active_mark[c.voice] || voice_ids[c.voice] != c.ticket) begin
        expected_reports.push_back(report(1'b0, c.voice, '0, 1));
        return;
      end
      case (c.mode)
        MODE_PITCH:  flag_bits[c.voice] |= FL_PITCH;
        MODE_VOLUME: flag_bits[c.voice] |= FL_VOL;
        MODE_PAN:    flag_bits[c.voice] |= FL_PAN;
        default: begin
          if (used_count > 0) begin
            used_count--;
            free_stack[used_count] = c.voice;
          end
          flag_bits[c.voice] = FL_STOP;
          active_mark[c.voice] = 1'b0;
        end
      endcase
      expected_reports.push_back(report(1'b1, c.voice, '0, 1));
    endfunction

    function void check_report(voice_report_t got);
      voice_report_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected transaction, voice_index %0d", $time, got.voice_index);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      if (want !== got) begin
        $display("%0t: mismatch expected ok=%0b idx=%0d id=%h act=%0b pos=%h fl=%h free=%0d",
                 $time, want.ok, want.voice_index, want.voice_id, want.active,
                 want.position, want.pending_flags, want.free_voices);
        $display("%0t:          actual   ok=%0b idx=%0d id=%h act=%0b pos=%h fl=%h free=%0d",
                 $time, got.ok, got.voice_index, got.voice_id, got.active,
                 got.position, got.pending_flags, got.free_voices);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  cmd_t cmd = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic ok, active;
  logic [5:0] voice_index;
  logic [31:0] voice_id, position;
  logic [4:0] pending_flags;
  logic [6:0] free_voices;

  pool_scoreboard sb = new();
  bit calm = 0;
  bit done = 0;
  int idle_cycles = 0;
  logic [31:0] issued_ids[$];
  logic [5:0] issued_voice[$];

  always #6 clk = ~clk;

  voice_allocator_with_steal u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .mode(cmd.mode), .voice(cmd.voice), .ticket(cmd.ticket),
    .instrument(cmd.instrument), .start_position(cmd.start_position),
    .wave_length(cmd.wave_length), .loop_end(cmd.loop_end),
    .loop_count(cmd.loop_count), .pitch(cmd.pitch), .volume(cmd.volume),
    .pan(cmd.pan), .steal_priority(cmd.steal_priority),
    .out_valid(out_valid), .out_stall(out_stall), .ok(ok),
    .voice_index(voice_index), .voice_id(voice_id), .active(active),
    .position(position), .pending_flags(pending_flags), .free_voices(free_voices)
  );

  always @(posedge clk) begin
    voice_report_t r;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid && !in_stall) sb.note_command(cmd);
      if (out_valid && !out_stall) begin
        r.ok = ok; r.voice_index = voice_index; r.voice_id = voice_id;
        r.active = active; r.position = position;
        r.pending_flags = pending_flags; r.free_voices = free_voices;
        sb.check_report(r);
        if (ok && voice_index < NVOICES && sb.active_mark[voice_index]) begin
          issued_ids.push_back(sb.voice_ids[voice_index]);
          issued_voice.push_back(voice_index);
          if (issued_ids.size() > 32) begin
            void'(issued_ids.pop_front());
            void'(issued_voice.pop_front());
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[voice_allocator_with_steal] ERROR");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= (!calm && $urandom_range(99) < 24);
  end

  function automatic cmd_t random_fields(logic [2:0] m);
    cmd_t c;
    c.kind = K_ALLOC;
    c.mode = m;
    c.voice = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(NVOICES - 1));
    c.ticket = $urandom;
    c.instrument = $urandom;
    c.start_position = $urandom;
    c.wave_length = $urandom;
    c.loop_end = $urandom;
    c.loop_count = 8'($urandom);
    c.pitch = 16'($urandom);
    c.volume = 8'($urandom);
    c.pan = 8'($urandom);
    c.steal_priority = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
    return c;
  endfunction

  task automatic send_command(cmd_t c);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    cmd <= c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // query only out-of-range voices or voices that have been allocated at least once
  function automatic bit voice_written(logic [5:0] v);
    return v >= NVOICES || sb.voice_ids[v] != 0 || sb.active_mark[v];
  endfunction

  task automatic send_random();
    cmd_t c;
    int k;
    int pick;
    k = $urandom_range(99);
    if (k < 30) c = random_fields(MODE_ALLOC);
    else if (k < 96) begin
      c = random_fields(3'($urandom_range(MODE_PITCH, MODE_QUERY)));
      if (issued_ids.size() > 0 && $urandom_range(9) < 8) begin
        pick = $urandom_range(issued_ids.size() - 1);
        c.voice = issued_voice[pick];
        c.ticket = issued_ids[pick];
      end
    end else c = random_fields(3'($urandom_range(6, 7)));
    if (c.mode == MODE_QUERY && !voice_written(c.voice)) c.mode = MODE_PITCH;
    send_command(c);
  endtask

  initial begin
    cmd_t c;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    c = random_fields(MODE_ALLOC);
    c.instrument = '1; c.start_position = '1; c.wave_length = '1; c.loop_end = '1;
    c.loop_count = '1; c.pitch = '1; c.volume = '1; c.pan = '1; c.steal_priority = '1;
    send_command(c);
    c = random_fields(MODE_ALLOC);
    c.instrument = '0; c.start_position = '0; c.wave_length = '0; c.loop_end = '0;
    c.loop_count = '0; c.pitch = '0; c.volume = '0; c.pan = '0; c.steal_priority = '0;
    send_command(c);
    for (int m = MODE_PITCH; m <= MODE_STOP; m++) begin
      c = random_fields(3'(m)); c.voice = 6'd0; c.ticket = 32'd1; send_command(c);
    end
    c = random_fields(MODE_QUERY); c.voice = 6'd0; send_command(c);
    c = random_fields(MODE_PITCH); c.voice = 6'd1; c.ticket = 32'd7; send_command(c);
    c = random_fields(MODE_QUERY); c.voice = 6'd63; send_command(c);
    c = random_fields(3'd6); send_command(c);
    c = random_fields(3'd7); c.voice = 6'd0; send_command(c);
    // fill the pool (the last of these allocates steals), then a refused allocate and a steal
    repeat (NVOICES) begin
      c = random_fields(MODE_ALLOC); c.steal_priority = 8'd1; send_command(c);
    end
    c = random_fields(MODE_ALLOC); c.steal_priority = 8'd0; send_command(c);
    c = random_fields(MODE_ALLOC); c.steal_priority = 8'd128; send_command(c);
    for (int i = 0; i < 1700; i++) begin
      calm = (i >= 600 && i < 900);
      send_random();
    end
    in_valid <= 1'b0;
    calm = 0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (2 * NVOICES + 20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_reports.size() == 0)
      $display("[voice_allocator_with_steal] OK");
    else
      $display("[voice_allocator_with_steal] ERROR");
    $finish;
  end
endmodule

[files.f]
hdl/vas_pkg.sv
hdl/vas_front.sv
hdl/vas_queue.sv
hdl/vas_back.sv
hdl/voice_allocator_with_steal.sv
bench/tb_top.sv
